// ===== rtl/dpmss_pkg.sv =====
// Constants shared by the dual potentiometer motor/servo setpoint block.
// Window length, field widths and fixed-point reciprocals for the constant divides.
// No dependencies.
`default_nettype none

package dpmss_pkg;

    // moving average window, legal range 2..16
    localparam int unsigned WINDOW_LENGTH = 10;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned SUM_W    = 14;

    // fraction bits of every reciprocal below; rounding up makes each one exact
    // over the operand ranges used here
    localparam int unsigned FRAC_BITS = 20;

    // ceil(2^20 / WINDOW_LENGTH)
    localparam int unsigned AVG_RECIP_W = 20;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << FRAC_BITS) + 64'(WINDOW_LENGTH) - 64'd1)
                      / 64'(WINDOW_LENGTH));

    // ceil(198 * 2^20 / 1023) and ceil(180 * 2^20 / 1023)
    localparam int unsigned SCALE_RECIP_W = 18;
    localparam logic [SCALE_RECIP_W-1:0] SPD_RECIP =
        SCALE_RECIP_W'(((64'd198 << FRAC_BITS) + 64'd1022) / 64'd1023);
    localparam logic [SCALE_RECIP_W-1:0] ANG_RECIP =
        SCALE_RECIP_W'(((64'd180 << FRAC_BITS) + 64'd1022) / 64'd1023);

    // ceil(2000 * 2^20 / 99)
    localparam int unsigned MOTOR_RECIP_W = 25;
    localparam logic [MOTOR_RECIP_W-1:0] MOTOR_RECIP =
        MOTOR_RECIP_W'(((64'd2000 << FRAC_BITS) + 64'd98) / 64'd99);

    localparam logic [8:0]  SPD_CENTRE  = 9'd99;
    localparam logic [8:0]  ANG_CENTRE  = 9'd90;
    localparam logic [13:0] SERVO_BASE  = 14'd3000;
    localparam logic [5:0]  SERVO_STEP  = 6'd50;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 64;

endpackage

`default_nettype wire

// ===== rtl/dual_pot_motor_servo_setpoint.sv =====
// Dual potentiometer motor/servo setpoint: moving averages, scaling, H-bridge bits
// and PWM compare values. Depends on dpmss_pkg.
`default_nettype none
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    speed and angle samples
//  m_axis   out  m_axis_tvalid/m_axis_tready    setpoints, bridge bits, pulse widths
//
//  One transaction per cycle while m_axis_tready stays high; m_axis_tvalid rises once the
//  item passes the sum update (on the accept edge), average, scaling and output registers.
//  Synchronous active-low reset clears the sample histories, window sums and all
//  valid flags; the averages ramp up over the first WINDOW_LENGTH transactions.
//  Each stage advances whenever the stage after it is empty or moving, so bubbles
//  close up and input is taken while a result waits on m_axis_tready, until the stages fill.

module dual_pot_motor_servo_setpoint
    import dpmss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] speed_sample, [19:10] angle_sample, [23:20] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] speed_signed, [14:8] speed_magnitude, [22:15] angle_signed,
    // [30:23] angle_absolute, [31] bridge_in1, [32] bridge_in2,
    // [43:33] motor_pulse_ticks, [57:44] servo_pulse_ticks, [63:58] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // sample histories, newest at index 0
    logic [SAMPLE_W-1:0] r_spd_hist [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] r_ang_hist [WINDOW_LENGTH];
    logic [SUM_W-1:0]    r_spd_sum, r_ang_sum;
    logic [SUM_W-1:0]    n_spd_sum, n_ang_sum;

    logic                r_v1, r_v2, r_v3, r_vo;
    logic [SAMPLE_W-1:0] r_spd_avg, r_ang_avg;
    logic [7:0]          r_spd_scaled, r_ang_abs;
    logic [OUT_DATA_W-1:0] r_out;

    logic en_s1, en_s2, en_s3, en_out, accept;
    logic [SAMPLE_W-1:0] spd_sample, ang_sample;

    assign en_out = !r_vo || m_axis_tready;
    assign en_s3  = !r_v3 || en_out;
    assign en_s2  = !r_v2 || en_s3;
    assign en_s1  = !r_v1 || en_s2;
    assign s_axis_tready = en_s1;
    assign accept = s_axis_tvalid && en_s1;

    assign spd_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign ang_sample = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

    // oldest sample leaves the window, new one enters
    assign n_spd_sum = r_spd_sum - SUM_W'(r_spd_hist[WINDOW_LENGTH-1]) + SUM_W'(spd_sample);
    assign n_ang_sum = r_ang_sum - SUM_W'(r_ang_hist[WINDOW_LENGTH-1]) + SUM_W'(ang_sample);

    // stage 1: history and window sums (the sums are the stage payload)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                r_spd_hist[k] <= '0;
                r_ang_hist[k] <= '0;
            end
            r_spd_sum <= '0;
            r_ang_sum <= '0;
        end else if (accept) begin
            r_spd_hist[0] <= spd_sample;
            r_ang_hist[0] <= ang_sample;
            for (int k = 1; k < WINDOW_LENGTH; k++) begin
                r_spd_hist[k] <= r_spd_hist[k-1];
                r_ang_hist[k] <= r_ang_hist[k-1];
            end
            r_spd_sum <= n_spd_sum;
            r_ang_sum <= n_ang_sum;
        end
    end

    // stage 2: divide by the window length
    logic [SUM_W+AVG_RECIP_W-1:0] spd_avg_prod, ang_avg_prod;
    assign spd_avg_prod = (SUM_W+AVG_RECIP_W)'(r_spd_sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);
    assign ang_avg_prod = (SUM_W+AVG_RECIP_W)'(r_ang_sum) * (SUM_W+AVG_RECIP_W)'(AVG_RECIP);

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_spd_avg <= spd_avg_prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            r_ang_avg <= ang_avg_prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        end
    end

    // stage 3: scale to 0..198 and 0..180
    logic [SAMPLE_W+SCALE_RECIP_W-1:0] spd_sc_prod, ang_sc_prod;
    assign spd_sc_prod = (SAMPLE_W+SCALE_RECIP_W)'(r_spd_avg)
                       * (SAMPLE_W+SCALE_RECIP_W)'(SPD_RECIP);
    assign ang_sc_prod = (SAMPLE_W+SCALE_RECIP_W)'(r_ang_avg)
                       * (SAMPLE_W+SCALE_RECIP_W)'(ANG_RECIP);

    always_ff @(posedge i_clk) begin
        if (en_s3) begin
            r_spd_scaled <= spd_sc_prod[FRAC_BITS+7:FRAC_BITS];
            r_ang_abs    <= ang_sc_prod[FRAC_BITS+7:FRAC_BITS];
        end
    end

    // output stage: centre, direction, pulse widths
    logic signed [8:0] spd_diff, ang_diff;
    logic [6:0]        spd_mag;
    logic              bridge_in1, bridge_in2;
    logic [31:0]       motor_prod;
    logic [10:0]       motor_ticks;
    logic [13:0]       servo_ticks;

    always_comb begin
        spd_diff    = $signed({1'b0, r_spd_scaled}) - $signed(SPD_CENTRE);
        ang_diff    = $signed({1'b0, r_ang_abs}) - $signed(ANG_CENTRE);
        spd_mag     = spd_diff[8] ? 7'(-spd_diff) : spd_diff[6:0];
        bridge_in1  = !spd_diff[8];
        bridge_in2  = spd_diff[8] || (spd_diff == 9'sd0);
        motor_prod  = 32'(spd_mag) * 32'(MOTOR_RECIP);
        motor_ticks = motor_prod[FRAC_BITS+10:FRAC_BITS];
        servo_ticks = SERVO_BASE + 14'(r_ang_abs) * 14'(SERVO_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= {6'd0, servo_ticks, motor_ticks, bridge_in2, bridge_in1,
                      r_ang_abs, ang_diff[7:0], spd_mag, spd_diff[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_s1)  r_v1 <= accept;
            if (en_s2)  r_v2 <= r_v1;
            if (en_s3)  r_v3 <= r_v2;
            if (en_out) r_vo <= r_v3;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

    // running sum must match the history contents
    logic [SUM_W-1:0] spd_sum_chk;
    always_comb begin
        spd_sum_chk = '0;
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
            spd_sum_chk = spd_sum_chk + SUM_W'(r_spd_hist[k]);
        end
    end

    a_sum_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spd_sum == spd_sum_chk)
        else $error("speed window sum out of step with history");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted transaction not in stage one");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !en_out |=> r_v3 && $stable(r_spd_scaled) && $stable(r_ang_abs))
        else $error("stalled stage three lost its item");

    a_never_both_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_out[31] || r_out[32]))
        else $error("both bridge inputs low");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_out[43:33] <= 11'd2000 && r_out[57:44] <= 14'd12000
                  && r_out[57:44] >= 14'd3000))
        else $error("pulse width out of range");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for dual_pot_motor_servo_setpoint.
// Predicts the moving-average setpoints per transaction and checks each m_axis result.
// Depends on dpmss_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench
    import dpmss_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PAD_W = IN_DATA_W - 2 * SAMPLE_W;
    localparam int unsigned SLOT_W = $clog2(WINDOW_LENGTH);

    // one result, fields as carried on m_axis_tdata
    typedef struct {
        logic [7:0]  spd_signed;
        logic [6:0]  spd_mag;
        logic [7:0]  ang_signed;
        logic [7:0]  ang_abs;
        logic        in1;
        logic        in2;
        logic [10:0] motor_ticks;
        logic [13:0] servo_ticks;
    } t_setpoint;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [9:0] speed_sample, [19:10] angle_sample, [23:20] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] speed_signed, [14:8] speed_magnitude, [22:15] angle_signed,
    // [30:23] angle_absolute, [31] bridge_in1, [32] bridge_in2,
    // [43:33] motor_pulse_ticks, [57:44] servo_pulse_ticks, [63:58] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    dual_pot_motor_servo_setpoint u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [SAMPLE_W-1:0] speed_ring [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] angle_ring [WINDOW_LENGTH];
    logic [SUM_W-1:0]    speed_sum;
    logic [SUM_W-1:0]    angle_sum;
    logic [SLOT_W-1:0]   ring_slot;

    t_setpoint   expected_setpoints [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b0;
    int unsigned sink_hold_cycles = 0;

    function automatic t_setpoint predict_setpoint(input logic [SAMPLE_W-1:0] spd,
                                                   input logic [SAMPLE_W-1:0] ang);
        t_setpoint   r;
        int unsigned spd_avg, ang_avg, ang_abs, mag;
        int          spd_s;
        speed_sum = speed_sum - SUM_W'(speed_ring[ring_slot]) + SUM_W'(spd);
        angle_sum = angle_sum - SUM_W'(angle_ring[ring_slot]) + SUM_W'(ang);
        speed_ring[ring_slot] = spd;
        angle_ring[ring_slot] = ang;
        ring_slot = (ring_slot == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : ring_slot + 1'b1;

        spd_avg = speed_sum / WINDOW_LENGTH;
        ang_avg = angle_sum / WINDOW_LENGTH;
        spd_s   = int'((spd_avg * 198) / 1023) - 99;
        mag     = (spd_s < 0) ? -spd_s : spd_s;
        ang_abs = (ang_avg * 180) / 1023;

        r.spd_signed  = 8'(spd_s);
        r.spd_mag     = 7'(mag);
        r.ang_signed  = 8'(int'(ang_abs) - 90);
        r.ang_abs     = 8'(ang_abs);
        r.in1         = (spd_s >= 0);
        r.in2         = (spd_s <= 0);
        r.motor_ticks = 11'((mag * 2000) / 99);
        r.servo_ticks = 14'(3000 + 50 * ang_abs);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin : result_checker
        t_setpoint want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_setpoints.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[15:0], '0);
            end else begin
                want = expected_setpoints.pop_front();
                check_field("speed_signed",      m_axis_tdata[7:0],   want.spd_signed);
                check_field("speed_magnitude",   m_axis_tdata[14:8],  want.spd_mag);
                check_field("angle_signed",      m_axis_tdata[22:15], want.ang_signed);
                check_field("angle_absolute",    m_axis_tdata[30:23], want.ang_abs);
                check_field("bridge_in1",        m_axis_tdata[31],    want.in1);
                check_field("bridge_in2",        m_axis_tdata[32],    want.in2);
                check_field("motor_pulse_ticks", m_axis_tdata[43:33], want.motor_ticks);
                check_field("servo_pulse_ticks", m_axis_tdata[57:44], want.servo_ticks);
                check_field("tdata padding",     m_axis_tdata[63:58], '0);
            end
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin : sink_drive
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles != 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles <= 0;
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_samples(input logic [SAMPLE_W-1:0] spd, input logic [SAMPLE_W-1:0] ang);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, ang, spd};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_setpoints.push_back(predict_setpoint(spd, ang));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_setpoints.size() != 0)
            @(posedge i_clk);
    endtask

    // biased towards the end stops and the brake band around mid-scale
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(511, 517));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // rings start at zero, so the averages climb over one window; slot wraps at the end
    task automatic test_startup_ramp();
        repeat (WINDOW_LENGTH) send_samples('1, '1);
    endtask

    // ramp down to mid-scale speed (brake), zero angle; alternating bit patterns; full angle
    task automatic test_directed_patterns();
        repeat (WINDOW_LENGTH) send_samples(10'd512, '0);
        repeat (2) begin
            send_samples(10'h2AA, 10'h155);
            send_samples(10'h155, 10'h2AA);
        end
        send_samples(10'd516, 10'd1023);
    endtask

    // noise mixed with held levels long enough for the averages to settle, with random gaps and stalls
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned run;
        logic [SAMPLE_W-1:0] spd, ang;
        sent = 0;
        idle_on = 1'b1;
        while (sent < 300) begin
            if ($urandom_range(0, 9) < 6) begin
                run = $urandom_range(1, 12);
                repeat (run) send_samples(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
            end else begin
                run = $urandom_range(WINDOW_LENGTH, WINDOW_LENGTH + 3);
                spd = pick_sample();
                ang = pick_sample();
                repeat (run) send_samples(spd, ang);
            end
            sent += run;
        end
    endtask

    // receiver holds off while the sender keeps offering, so the pipeline backs up
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        sink_hold_cycles <= 150;
        repeat (40) send_samples(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        wait_for_results();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (60) send_samples(pick_sample(), SAMPLE_W'($urandom()));
    endtask

    initial begin
        foreach (speed_ring[k]) begin
            speed_ring[k] = '0;
            angle_ring[k] = '0;
        end
        speed_sum = '0;
        angle_sum = '0;
        ring_slot = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_startup_ramp();
        test_directed_patterns();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
